// ----- rtl/fsmf_pkg.sv -----
// Shared types and constants for the first substring match finder.
package fsmf_pkg;

   localparam int PATTERN_MAX_DEF   = 16;
   localparam int POSITION_BITS_DEF = 16;

   localparam int TEXT_W      = 8;
   localparam int START_W     = 16;
   localparam int LEN_W       = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_HALF_BYTES = CSR_DATA_W / TEXT_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN  = 2'd2;

   typedef struct packed {
      logic              fire;
      logic [TEXT_W-1:0] text_byte;
      logic              last;
   } step_type;

   typedef struct packed {
      logic               found;
      logic [START_W-1:0] start;
      logic               overflow;
   } result_type;

endpackage

// ----- rtl/first_substring_match_finder_unit.sv -----
// Top level of the first substring match finder.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_text_byte, req_last_of_text
//   rsp      out  rsp_valid/rsp_ready    rsp_match_found, rsp_match_start,
//                                        rsp_count_overflow
//   csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// One request per cycle while req_ready is high; a request is held in the input
// register, and the window compare and state update run between it and the result
// register. rsp_valid is registered once a last request leaves the input stage.
// Synchronous reset clears configuration and search state; no clearing pass.
// While a response is stalled, requests keep flowing; only a second last
// request waits in the input register, so req_ready drops then.
module first_substring_match_finder_unit #(
   parameter int PATTERN_MAX   = fsmf_pkg::PATTERN_MAX_DEF,
   parameter int POSITION_BITS = fsmf_pkg::POSITION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fsmf_pkg::TEXT_W-1:0]       req_text_byte,
   input  logic                              req_last_of_text,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_match_found,
   output logic [fsmf_pkg::START_W-1:0]      rsp_match_start,
   output logic                              rsp_count_overflow,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fsmf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fsmf_pkg::CSR_DATA_W-1:0]   csr_data
);
   import fsmf_pkg::*;

   localparam int LW = $clog2(PATTERN_MAX + 1);

   logic [PATTERN_MAX-1:0][TEXT_W-1:0] pattern;
   logic [LW-1:0]                      used_len;

   logic              s1_valid_ff, s1_valid_in;
   logic [TEXT_W-1:0] s1_byte_ff;
   logic              s1_last_ff;
   logic              s1_advance;
   logic              req_fire;

   step_type          step;
   result_type        step_result;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;

   assign csr_ready = 1'b1;

   fsmf_cfg_regs #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .pattern  (pattern),
      .used_len (used_len)
   );

   assign s1_advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_fire   = req_valid && req_ready;
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_text_byte;
         s1_last_ff <= req_last_of_text;
      end
   end

   assign step.fire      = s1_advance;
   assign step.text_byte = s1_byte_ff;
   assign step.last      = s1_last_ff;

   fsmf_search #(
      .PATTERN_MAX   (PATTERN_MAX),
      .POSITION_BITS (POSITION_BITS)
   ) u_search (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .pattern  (pattern),
      .used_len (used_len),
      .result   (step_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (s1_advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_last_ff) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_found    = rsp_ff.found;
   assign rsp_match_start    = rsp_ff.start;
   assign rsp_count_overflow = rsp_ff.overflow;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_last_ff) |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten while stalled");

   a_rsp_follows_last: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_last_ff) |=> rsp_valid)
      else $error("last request did not produce a response");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_match_found) |-> (rsp_match_start == '0))
      else $error("nonzero match start without a match");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_ready))
      else $error("request stalled without a pending response");

endmodule

// ----- rtl/fsmf_cfg_regs.sv -----
// Pattern and pattern length configuration registers.
module fsmf_cfg_regs #(
   parameter int PATTERN_MAX = fsmf_pkg::PATTERN_MAX_DEF,
   localparam int LW = $clog2(PATTERN_MAX + 1)
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      wr_en,
   input  logic [fsmf_pkg::CSR_INDEX_W-1:0]          wr_index,
   input  logic [fsmf_pkg::CSR_DATA_W-1:0]           wr_data,
   output logic [PATTERN_MAX-1:0][fsmf_pkg::TEXT_W-1:0] pattern,
   output logic [LW-1:0]                             used_len
);
   import fsmf_pkg::*;

   logic [PATTERN_MAX-1:0][TEXT_W-1:0] pattern_ff;
   logic [LEN_W-1:0]                   len_ff;

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_byte
      localparam int LSB = (j % CSR_HALF_BYTES) * TEXT_W;
      localparam logic [CSR_INDEX_W-1:0] SEL =
         (j < CSR_HALF_BYTES) ? CSR_PATTERN_LOW : CSR_PATTERN_HIGH;
      always_ff @(posedge clock) begin
         if (reset) begin
            pattern_ff[j] <= '0;
         end else if (wr_en && wr_index == SEL) begin
            pattern_ff[j] <= wr_data[LSB +: TEXT_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (wr_en && wr_index == CSR_PATTERN_LEN) begin
         len_ff <= wr_data[LEN_W-1:0];
      end
   end

   assign pattern  = pattern_ff;
   assign used_len = (len_ff > LEN_W'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : LW'(len_ff);

endmodule

// ----- rtl/fsmf_search.sv -----
// Byte window, position counter and first-match tracking.
module fsmf_search #(
   parameter int PATTERN_MAX   = fsmf_pkg::PATTERN_MAX_DEF,
   parameter int POSITION_BITS = fsmf_pkg::POSITION_BITS_DEF,
   localparam int LW = $clog2(PATTERN_MAX + 1)
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  fsmf_pkg::step_type                           step,
   input  logic [PATTERN_MAX-1:0][fsmf_pkg::TEXT_W-1:0] pattern,
   input  logic [LW-1:0]                                used_len,
   output fsmf_pkg::result_type                         result
);
   import fsmf_pkg::*;

   logic [PATTERN_MAX-1:0][TEXT_W-1:0] window_ff, window_in;
   logic [POSITION_BITS:0]             count_ff, count_in;
   logic                               found_ff, found_in;
   logic [POSITION_BITS-1:0]           index_ff, index_in;
   logic                               ovf_ff, ovf_in;

   logic                               counted;
   logic [PATTERN_MAX:0]               match_vec;
   logic                               hit;
   logic [POSITION_BITS:0]             index_calc;
   logic [POSITION_BITS+START_W-1:0]   index_wide;

   always_comb begin
      window_in[0] = step.text_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   // match_vec[n]: newest n window bytes equal pattern bytes 0..n-1
   always_comb begin
      match_vec[0] = 1'b1;
      for (int n = 1; n <= PATTERN_MAX; n++) begin
         match_vec[n] = 1'b1;
         for (int j = 0; j < n; j++) begin
            if (window_in[n-1-j] != pattern[j]) begin
               match_vec[n] = 1'b0;
            end
         end
      end
   end

   assign counted    = !count_ff[POSITION_BITS];
   assign count_in   = counted ? count_ff + 1'b1 : count_ff;
   assign ovf_in     = ovf_ff | !counted;
   assign index_calc = count_in - (POSITION_BITS+1)'(used_len);

   assign hit = counted && !found_ff &&
                (used_len == '0 ||
                 (count_in >= (POSITION_BITS+1)'(used_len) && match_vec[used_len]));

   assign found_in = found_ff | hit;

   always_comb begin
      index_in = index_ff;
      if (hit) begin
         index_in = (used_len == '0) ? '0 : index_calc[POSITION_BITS-1:0];
      end
   end

   assign index_wide      = {{START_W{1'b0}}, index_in};
   assign result.found    = found_in;
   assign result.start    = found_in ? index_wide[START_W-1:0] : '0;
   assign result.overflow = ovf_in;

   always_ff @(posedge clock) begin
      if (reset || (step.fire && step.last)) begin
         window_ff <= '0;
         count_ff  <= '0;
         found_ff  <= 1'b0;
         index_ff  <= '0;
         ovf_ff    <= 1'b0;
      end else if (step.fire) begin
         window_ff <= window_in;
         count_ff  <= count_in;
         found_ff  <= found_in;
         index_ff  <= index_in;
         ovf_ff    <= ovf_in;
      end
   end

endmodule
